@@ rtl/core/bpru_pkg.sv @@
// ============================================================================
// Bitmap pixel row unpacker package
// Transaction types, register map, depth codes and fixed limits shared by
// the unpacker RTL.
// ============================================================================
package bpru_pkg;

    // Fixed limits of the image geometry.
    localparam int unsigned MAX_WIDTH     = 4096;
    localparam int unsigned MAX_HEIGHT    = 4096;
    localparam int unsigned PALETTE_DEPTH = 256;

    // Widths of the configuration port and of the internal counters.
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned DIM_W       = 13;
    localparam int unsigned COORD_W     = 12;
    localparam int unsigned POS_W       = 14;
    localparam int unsigned PAL_IDX_W   = 8;
    localparam int unsigned COLOR_W     = 24;

    // Reciprocal of three for the 24-bit column: x = (pos * 0xAAAB) >> 17,
    // exact for every position below 2**16.
    localparam logic [16:0] DIV3_RECIP = 17'h0AAAB;
    localparam int unsigned DIV3_SHIFT = 17;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_DEPTH_MODE    = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_SWAP_RED_BLUE = 2'd3;

    // Pixel depth codes.
    localparam logic [1:0] DEPTH_1BIT  = 2'd0;
    localparam logic [1:0] DEPTH_4BIT  = 2'd1;
    localparam logic [1:0] DEPTH_8BIT  = 2'd2;
    localparam logic [1:0] DEPTH_24BIT = 2'd3;

    // Input command codes.
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_DATA    = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        run_last;
        logic        image_last;
    } out_item_t;

endpackage : bpru_pkg

@@ rtl/core/bmp_pixel_row_unpacker_unit.sv @@
// ============================================================================
// Bitmap pixel row unpacker
// Unpacks raw bytes of an uncompressed bitmap at 1, 4, 8 or 24 bits per pixel
// into coordinate-tagged pixels, looking packed pixels up in a 256-entry
// palette held in a synchronous RAM and skipping row padding.
// ============================================================================
//
//  Channel   Ports                               Carries
//  --------  ----------------------------------  -------------------------------
//  input     s_valid / s_ready / s_data          palette writes and image bytes
//  result    m_valid / m_ready / m_data          one pixel per transaction
//  config    psel/penable/pwrite/paddr/pwdata    depth, width, height, swap
//
//  The expansion stage issues pixels one at a time while the read stage is free
//  (the palette has a single read port): up to eight per byte in 1-bit mode, up
//  to two in 4-bit mode, otherwise at most one. Palette writes, padding bytes
//  and partial 24-bit pixels yield none and do not wait for the read stage.
//  Reset (aresetn low, synchronous) clears the counters, empties the pipeline
//  and restores the register defaults; palette contents are undefined until written.
//  A stall on the result side fills the output and read stages, then holds
//  s_ready low while pixels wait in the expansion stage; no transaction is lost.
//
module bmp_pixel_row_unpacker_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bpru_pkg::in_item_t                  s_data,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output bpru_pkg::out_item_t                 m_data,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpru_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bpru_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bpru_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import bpru_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]       depth_mode_reg;
    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic             swap_red_blue_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register write on the access phase of an APB transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_mode_reg    <= DEPTH_24BIT;
            image_width_reg   <= DIM_W'(1);
            image_height_reg  <= DIM_W'(1);
            swap_red_blue_reg <= 1'b1;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_DEPTH_MODE:    depth_mode_reg    <= pwdata[1:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[DIM_W-1:0];
                REG_SWAP_RED_BLUE: swap_red_blue_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_DEPTH_MODE:    prdata = APB_DATA_W'(depth_mode_reg);
            REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(image_height_reg);
            REG_SWAP_RED_BLUE: prdata = APB_DATA_W'(swap_red_blue_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective geometry: zero reads as one, large values saturate.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [16:0]      row_bits;
    logic [17:0]      row_bits_rnd;
    logic [POS_W-1:0] stride;
    logic [14:0]      width_x3;

    always_comb begin
        if (image_width_reg == '0) begin
            width_eff = DIM_W'(1);
        end else if (image_width_reg > DIM_W'(MAX_WIDTH)) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = image_width_reg;
        end
        if (image_height_reg == '0) begin
            height_eff = DIM_W'(1);
        end else if (image_height_reg > DIM_W'(MAX_HEIGHT)) begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            height_eff = image_height_reg;
        end
    end

    // Row length in bits, then padded to a whole number of 32-bit words.
    always_comb begin
        unique case (depth_mode_reg)
            DEPTH_1BIT:  row_bits = 17'(width_eff);
            DEPTH_4BIT:  row_bits = {2'b00, width_eff, 2'b00};
            DEPTH_8BIT:  row_bits = {1'b0, width_eff, 3'b000};
            DEPTH_24BIT: row_bits = {width_eff, 4'b0000} + {1'b0, width_eff, 3'b000};
            default:     row_bits = '0;
        endcase
    end

    assign row_bits_rnd = {1'b0, row_bits} + 18'd31;
    assign stride       = {row_bits_rnd[16:5], 2'b00};
    assign width_x3     = {1'b0, width_eff, 1'b0} + {2'b00, width_eff};

    // ------------------------------------------------------------------
    // Row state, advanced as each image byte is accepted.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   row_byte_count_reg, row_byte_count_next;
    logic [COORD_W-1:0] row_count_reg, row_count_next;
    logic [1:0]         channel_phase_reg, channel_phase_next;
    logic [15:0]        partial_color_reg, partial_color_next;

    logic        s_accept;
    logic        is_data;
    logic        row_end;
    logic        last_row;
    logic [16:0] x0;
    logic [3:0]  per_byte;
    logic [DIM_W-1:0] rem_pix;
    logic [3:0]  pix_count;
    logic        in_pixels24;
    logic        emit24;
    logic [COLOR_W-1:0] direct_color;
    logic [7:0]  byte_in;

    assign s_accept = s_valid && s_ready;
    assign is_data  = (s_data.command == CMD_DATA);
    assign byte_in  = s_data.data_byte;
    assign row_end  = ({1'b0, row_byte_count_reg} + 15'd1) >= {1'b0, stride};
    assign last_row = ({1'b0, row_count_reg} + 13'd1) >= height_eff;

    // First column of this byte and pixels per byte for the packed depths.
    always_comb begin
        unique case (depth_mode_reg)
            DEPTH_1BIT: begin
                x0       = {row_byte_count_reg, 3'b000};
                per_byte = 4'd8;
            end
            DEPTH_4BIT: begin
                x0       = {2'b00, row_byte_count_reg, 1'b0};
                per_byte = 4'd2;
            end
            default: begin
                x0       = {3'b000, row_byte_count_reg};
                per_byte = 4'd1;
            end
        endcase
    end

    // Number of pixels this byte yields before the row runs out of columns.
    always_comb begin
        rem_pix   = width_eff - x0[DIM_W-1:0];
        pix_count = 4'd0;
        if (x0 < 17'(width_eff)) begin
            if (rem_pix > DIM_W'(per_byte)) begin
                pix_count = per_byte;
            end else begin
                pix_count = rem_pix[3:0];
            end
        end
    end

    // 24-bit pixel assembly: the third channel byte completes the pixel.
    assign in_pixels24 = {1'b0, row_byte_count_reg} < width_x3;
    assign emit24      = in_pixels24 && (channel_phase_reg == 2'd2);

    always_comb begin
        if (swap_red_blue_reg) begin
            direct_color = {partial_color_reg[7:0], partial_color_reg[15:8], byte_in};
        end else begin
            direct_color = {byte_in, partial_color_reg[15:8], partial_color_reg[7:0]};
        end
    end

    always_comb begin
        row_byte_count_next = row_byte_count_reg;
        row_count_next      = row_count_reg;
        channel_phase_next  = channel_phase_reg;
        partial_color_next  = partial_color_reg;
        if (s_accept && is_data) begin
            if (depth_mode_reg == DEPTH_24BIT && in_pixels24) begin
                unique case (channel_phase_reg)
                    2'd0: begin
                        partial_color_next = {8'h00, byte_in};
                        channel_phase_next = 2'd1;
                    end
                    2'd1: begin
                        partial_color_next = {byte_in, partial_color_reg[7:0]};
                        channel_phase_next = 2'd2;
                    end
                    default: begin
                        channel_phase_next = 2'd0;
                    end
                endcase
            end
            if (row_end) begin
                row_byte_count_next = '0;
                channel_phase_next  = 2'd0;
                partial_color_next  = '0;
                row_count_next      = last_row ? '0 : row_count_reg + COORD_W'(1);
            end else begin
                row_byte_count_next = row_byte_count_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_byte_count_reg <= '0;
            row_count_reg      <= '0;
            channel_phase_reg  <= 2'd0;
            partial_color_reg  <= '0;
        end else begin
            row_byte_count_reg <= row_byte_count_next;
            row_count_reg      <= row_count_next;
            channel_phase_reg  <= channel_phase_next;
            partial_color_reg  <= partial_color_next;
        end
    end

    // ------------------------------------------------------------------
    // Expansion stage: holds one accepted transaction and issues one pixel
    // per cycle while the read stage is free (a palette read for packed depths).
    // ------------------------------------------------------------------
    logic                 e_valid_reg, e_valid_next;
    logic                 e_wr_reg;
    logic                 e_direct_reg;
    logic [3:0]           e_cnt_reg;
    logic [7:0]           e_sh_reg;
    logic [COORD_W-1:0]   e_x_reg;
    logic [COORD_W-1:0]   e_y_reg;
    logic                 e_last_row_reg;
    logic [POS_W-1:0]     e_pos_reg;
    logic [COLOR_W-1:0]   e_color_reg;
    logic [PAL_IDX_W-1:0] e_widx_reg;

    logic                 b_free;
    logic                 issue;
    logic                 e_done;
    logic                 rd_en;
    logic [PAL_IDX_W-1:0] rd_idx;
    logic [7:0]           sh_step;
    logic [30:0]          div3_prod;
    logic [COORD_W-1:0]   x24;

    assign issue   = e_valid_reg && !e_wr_reg && (e_cnt_reg != 4'd0) && b_free;
    assign e_done  = e_valid_reg &&
                     (e_wr_reg || (e_cnt_reg == 4'd0) || (issue && e_cnt_reg == 4'd1));
    assign s_ready = !e_valid_reg || e_done;
    assign rd_en   = issue && !e_direct_reg;

    // Palette index of the current pixel, most significant bits first.
    always_comb begin
        unique case (depth_mode_reg)
            DEPTH_1BIT: begin
                rd_idx  = {7'b0, e_sh_reg[7]};
                sh_step = {e_sh_reg[6:0], 1'b0};
            end
            DEPTH_4BIT: begin
                rd_idx  = {4'b0, e_sh_reg[7:4]};
                sh_step = {e_sh_reg[3:0], 4'b0000};
            end
            default: begin
                rd_idx  = e_sh_reg;
                sh_step = e_sh_reg;
            end
        endcase
    end

    // Column of a 24-bit pixel is the byte position divided by three.
    assign div3_prod = 31'(e_pos_reg) * 31'(DIV3_RECIP);
    assign x24       = div3_prod[DIV3_SHIFT+COORD_W-1:DIV3_SHIFT];

    always_comb begin
        e_valid_next = e_valid_reg;
        if (s_accept) begin
            e_valid_next = 1'b1;
        end else if (e_done) begin
            e_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else begin
            e_valid_reg <= e_valid_next;
        end
    end

    // Load a new transaction, or step through the pixels of the current one.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            e_wr_reg       <= !is_data;
            e_direct_reg   <= (depth_mode_reg == DEPTH_24BIT);
            e_sh_reg       <= byte_in;
            e_x_reg        <= x0[COORD_W-1:0];
            e_y_reg        <= row_count_reg;
            e_last_row_reg <= last_row;
            e_pos_reg      <= row_byte_count_reg;
            e_widx_reg     <= s_data.palette_index;
            if (!is_data) begin
                e_cnt_reg   <= 4'd0;
                e_color_reg <= {s_data.palette_red, s_data.palette_green,
                                s_data.palette_blue};
            end else if (depth_mode_reg == DEPTH_24BIT) begin
                e_cnt_reg   <= emit24 ? 4'd1 : 4'd0;
                e_color_reg <= direct_color;
            end else begin
                e_cnt_reg   <= pix_count;
                e_color_reg <= direct_color;
            end
        end else if (issue) begin
            e_cnt_reg <= e_cnt_reg - 4'd1;
            e_sh_reg  <= sh_step;
            e_x_reg   <= e_x_reg + COORD_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Palette RAM: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] pal_q_reg;

    always_ff @(posedge aclk) begin
        if (e_valid_reg && e_wr_reg) begin
            palette_mem[e_widx_reg] <= e_color_reg;
        end
        if (rd_en) begin
            pal_q_reg <= palette_mem[rd_idx];
        end
    end

    // ------------------------------------------------------------------
    // Read stage: pixel tags wait here alongside the palette read data.
    // ------------------------------------------------------------------
    logic               b_valid_reg, b_valid_next;
    logic [COORD_W-1:0] b_x_reg;
    logic [COORD_W-1:0] b_y_reg;
    logic               b_last_row_reg;
    logic               b_run_last_reg;
    logic               b_direct_reg;
    logic               b_swap_reg;
    logic [COLOR_W-1:0] b_color_reg;
    logic               b_move;

    logic               o_valid_reg, o_valid_next;
    out_item_t          o_data_reg;

    assign b_move = b_valid_reg && (!o_valid_reg || m_ready);
    assign b_free = !b_valid_reg || b_move;

    always_comb begin
        b_valid_next = b_valid_reg;
        if (issue) begin
            b_valid_next = 1'b1;
        end else if (b_move) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b_x_reg        <= e_direct_reg ? x24 : e_x_reg;
            b_y_reg        <= e_y_reg;
            b_last_row_reg <= e_last_row_reg;
            b_run_last_reg <= (e_cnt_reg == 4'd1);
            b_direct_reg   <= e_direct_reg;
            b_swap_reg     <= (depth_mode_reg == DEPTH_8BIT) && swap_red_blue_reg;
            b_color_reg    <= e_color_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: final color selection and end-of-image flag.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] pix_color;
    logic               pix_image_last;

    always_comb begin
        if (b_direct_reg) begin
            pix_color = b_color_reg;
        end else if (b_swap_reg) begin
            pix_color = {pal_q_reg[7:0], pal_q_reg[15:8], pal_q_reg[23:16]};
        end else begin
            pix_color = pal_q_reg;
        end
    end

    assign pix_image_last = b_last_row_reg &&
                            (({1'b0, b_x_reg} + DIM_W'(1)) == width_eff);

    always_comb begin
        o_valid_next = o_valid_reg;
        if (b_move) begin
            o_valid_next = 1'b1;
        end else if (m_ready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            o_data_reg.pixel_x    <= b_x_reg;
            o_data_reg.pixel_y    <= b_y_reg;
            o_data_reg.red        <= pix_color[23:16];
            o_data_reg.green      <= pix_color[15:8];
            o_data_reg.blue       <= pix_color[7:0];
            o_data_reg.run_last   <= b_run_last_reg;
            o_data_reg.image_last <= pix_image_last;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;

endmodule : bmp_pixel_row_unpacker_unit
